>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker in ptd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on clk and held off while rst_n is low.
`define PTD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with the clock and reset names of this project.
`define PTD_ASSERT_CLK(label, prop, msg) \
  `PTD_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/ptd_pkg.sv
package ptd_pkg;

  localparam int unsigned WIDTH_DEFAULT = 32;
  localparam int unsigned FIRST_DIVISOR = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_TEST
  } state_e;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic next_div;
  } cmd_t;

  typedef struct packed {
    logic lt_two;
    logic over_bound;
    logic div_last;
    logic rem_zero;
  } status_t;

endpackage

>>> rtl/core/ptd_datapath.sv
module ptd_datapath #(
  parameter int unsigned WIDTH = ptd_pkg::WIDTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] number_i,
  input  ptd_pkg::cmd_t    cmd_i,
  output ptd_pkg::status_t status_o
);

  localparam int unsigned DW = WIDTH / 2 + 1;
  localparam int unsigned SW = WIDTH + 1;
  localparam int unsigned CW = $clog2(WIDTH);

  logic [WIDTH-1:0] number_q;
  logic [WIDTH-1:0] shift_q;
  logic [DW-1:0]    divisor_q;
  logic [SW-1:0]    square_q;
  logic [DW-1:0]    rem_q;
  logic [CW-1:0]    count_q;

  logic [DW:0]      trial_rem;
  logic [DW:0]      trial_diff;
  logic [SW-1:0]    square_step;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign trial_rem   = {rem_q, shift_q[WIDTH-1]};
  assign trial_diff  = trial_rem - {1'b0, divisor_q};
  // (d+1)^2 = d^2 + 2d + 1
  assign square_step = square_q + SW'({divisor_q, 1'b1});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      number_q  <= number_i;
      divisor_q <= DW'(ptd_pkg::FIRST_DIVISOR);
      square_q  <= SW'(ptd_pkg::FIRST_DIVISOR * ptd_pkg::FIRST_DIVISOR);
    end else if (cmd_i.next_div) begin
      divisor_q <= divisor_q + DW'(1);
      square_q  <= square_step;
    end

    if (cmd_i.div_init) begin
      shift_q <= number_q;
      rem_q   <= '0;
      count_q <= CW'(WIDTH - 1);
    end else if (cmd_i.div_step) begin
      shift_q <= {shift_q[WIDTH-2:0], 1'b0};
      rem_q   <= (trial_rem >= {1'b0, divisor_q}) ? trial_diff[DW-1:0] : trial_rem[DW-1:0];
      count_q <= count_q - CW'(1);
    end
  end

  assign status_o.lt_two     = (number_q[WIDTH-1:1] == '0);
  assign status_o.over_bound = (square_q > {1'b0, number_q});
  assign status_o.div_last   = (count_q == '0);
  assign status_o.rem_zero   = (rem_q == '0);

endmodule

>>> rtl/core/ptd_controller.sv
module ptd_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ptd_pkg::status_t status_i,
  output ptd_pkg::cmd_t    cmd_o,
  output logic             done_o,
  output logic             is_prime_o
);

  ptd_pkg::state_e state_q, state_d;
  logic            done_q, done_d;
  logic            prime_q, prime_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptd_pkg::ST_IDLE;
      done_q  <= 1'b0;
      prime_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      prime_q <= prime_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    prime_d = prime_q;
    cmd_o   = '0;
    case (state_q)
      ptd_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ptd_pkg::ST_CHECK;
        end
      end
      ptd_pkg::ST_CHECK: begin
        if (status_i.lt_two) begin
          done_d  = 1'b1;
          prime_d = 1'b0;
          state_d = ptd_pkg::ST_IDLE;
        end else if (status_i.over_bound) begin
          done_d  = 1'b1;
          prime_d = 1'b1;
          state_d = ptd_pkg::ST_IDLE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ptd_pkg::ST_DIVIDE;
        end
      end
      ptd_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ptd_pkg::ST_TEST;
        end
      end
      ptd_pkg::ST_TEST: begin
        if (status_i.rem_zero) begin
          done_d  = 1'b1;
          prime_d = 1'b0;
          state_d = ptd_pkg::ST_IDLE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = ptd_pkg::ST_CHECK;
        end
      end
      default: begin
        state_d = ptd_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_q != ptd_pkg::ST_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

endmodule

>>> rtl/core/primality_trial_division_unit.sv
// Trial-division primality tester. Pulse start while busy is low to hand in
// one WIDTH-bit number; busy rises on the next cycle and stays high until the
// test ends. The verdict comes back as a single-cycle beat: done_o is high for
// exactly one cycle with is_prime_o valid beside it, and there is no way to
// hold it off, so the receiver must capture it in that cycle. Values 0 and 1
// report not prime. Otherwise divisors d = 2, 3, ... are tried while d*d is
// at most the number; each try runs a bound check, then the bit-serial
// remainder unit through every bit of the number, then a test of the
// remainder. The largest primes walk roughly 2^(WIDTH/2) divisors. A new
// number may be started in the same cycle the previous verdict is shown.
module primality_trial_division_unit #(
  parameter int unsigned WIDTH = ptd_pkg::WIDTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] number_i,
  output logic             done_o,
  output logic             is_prime_o
);

  ptd_pkg::cmd_t    cmd;
  ptd_pkg::status_t status;

  // Sequencer: walks check / divide / test per divisor and owns the verdict.
  ptd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .status_i   (status),
    .cmd_o      (cmd),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

  // Held number, divisor with its running square, and the remainder unit.
  ptd_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .number_i (number_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

>>> rtl/core/ptd_checker.sv
`include "assert_macros.svh"

module ptd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // An accepted beat makes the unit busy on the next cycle.
  `PTD_ASSERT_CLK(a_start_busy, (start && !busy) |=> busy, "busy did not rise after start")

  // The verdict beat is shown only once the unit is idle again.
  `PTD_ASSERT_CLK(a_done_idle, done_o |-> (!busy && $past(busy)), "done outside end of test")

  // Every end of a test delivers exactly one verdict beat.
  `PTD_ASSERT_CLK(a_fall_done, $fell(busy) |-> done_o, "test ended without a verdict")

  // The verdict strobe lasts a single cycle.
  `PTD_ASSERT_CLK(a_done_pulse, done_o |=> !done_o, "done held longer than one cycle")

endmodule

bind primality_trial_division_unit ptd_checker u_ptd_checker (.*);

>>> tb/tb_primality_trial_division_unit.sv
module tb_primality_trial_division_unit;

  localparam int unsigned W = ptd_pkg::WIDTH_DEFAULT;

  // An item's length grows with the number k of divisors tried. Random numbers
  // keep k under about 1024, and only two directed numbers walk about 4096
  // divisors; CYCLE_LIMIT stops a run that hangs.
  localparam longint unsigned CYCLE_LIMIT = 64'd16_000_000;
  // After the last verdict, keep watching for stray beats.
  localparam int unsigned DRAIN_CYCLES = 4 * (W + 2);
  localparam int unsigned RANDOM_BEATS = 80;

  typedef struct {
    logic [W-1:0] number;
    bit           prime;
  } verdict_t;

  // Track the numbers the block has taken and check each verdict beat in order.
  class verdict_board;
    verdict_t    pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Try d = 2, 3, ... while d*d <= n; test the bound as d <= n/d so it
    // cannot overflow. Values below 2 are never prime.
    function bit prime_by_trial(logic [W-1:0] n);
      longint unsigned value;
      longint unsigned d;
      value = n;
      if (value < ptd_pkg::FIRST_DIVISOR) return 1'b0;
      for (d = ptd_pkg::FIRST_DIVISOR; d <= value / d; d++) begin
        if (value % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic [W-1:0] n);
      verdict_t v;
      v.number = n;
      v.prime  = prime_by_trial(n);
      pending.push_back(v);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_verdict(logic got);
      verdict_t want;
      if (pending.size() == 0) begin
        report($sformatf("verdict beat %b with no number outstanding", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want.prime) begin
        report($sformatf("number %0d: is_prime %b, expected %b", want.number, got,
                         want.prime));
      end
    endtask

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         start;
  logic         busy;
  logic [W-1:0] number_i;
  logic         done_o;
  logic         is_prime_o;

  longint unsigned cycle_count = 0;
  verdict_board    board = new();

  // Small primes used to build multiples with a known small factor, so that
  // full-width values stop at a divisor of at most 97.
  int unsigned factor_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                     43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

  // Directed beats: zero and one, the smallest primes, squares of primes,
  // a prime and a prime square near 2^24 (the longest divisor walks of the
  // run), and full-width patterns with bit 31 both set and clear.
  logic [W-1:0] directed_numbers[20] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd97,
    32'd121, 32'd65537, 32'd1000003, 32'd16777213, 32'd16752649,
    32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
  };

  primality_trial_division_unit #(
    .WIDTH(W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .number_i  (number_i),
    .done_o    (done_o),
    .is_prime_o(is_prime_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL primality_trial_division_unit");
      $finish;
    end
  end

  // Capture every verdict beat: done_o lasts one cycle and cannot be held off,
  // so sample it at each edge once reset is released.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) board.check_verdict(is_prime_o);
  end

  // Present one number and hold start until an edge sees busy low; that edge
  // takes the beat. Leave start high so a back-to-back beat needs no toggle.
  task automatic drive_beat(logic [W-1:0] n);
    start    <= 1'b1;
    number_i <= n;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_number(n);
  endtask

  // Drop start for an idle gap and put a random value on the number bus
  // meanwhile; the block must ignore it.
  task automatic idle_gap(int unsigned cycles_n);
    if (cycles_n == 0) return;
    start    <= 1'b0;
    number_i <= $urandom;
    repeat (cycles_n) @(posedge clk_i);
  endtask

  // Mix of numbers: small values (many primes, short walks), full-width
  // multiples of a small known prime, and a few mid-size values whose
  // walks run up to about a thousand divisors.
  function automatic logic [W-1:0] pick_number();
    int unsigned kind;
    int unsigned p;
    kind = $urandom_range(0, 99);
    if (kind < 40) return $urandom_range(0, 32'h0000_FFFF);
    if (kind < 85) begin
      p = factor_primes[$urandom_range(0, 24)];
      return p * $urandom_range(1, 32'hFFFF_FFFF / p);
    end
    return $urandom_range(32'h0001_0000, 32'h000F_FFFF);
  endfunction

  initial begin
    int unsigned burst_left;
    rst_ni = 1'b0;
    start    <= 1'b0;
    number_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_numbers[i]) begin
      drive_beat(directed_numbers[i]);
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 5));
    end

    // Send in bursts; a burst ends in a gap of random length, sometimes none.
    burst_left = $urandom_range(1, 12);
    repeat (RANDOM_BEATS) begin
      drive_beat(pick_number());
      burst_left--;
      if (burst_left == 0) begin
        idle_gap($urandom_range(0, 9));
        burst_left = $urandom_range(1, 12);
      end
    end
    start <= 1'b0;

    // Wait out the last verdicts, then watch for stray beats.
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("PASS primality_trial_division_unit");
    end else begin
      $display("FAIL primality_trial_division_unit");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ptd_pkg.sv
rtl/core/ptd_datapath.sv
rtl/core/ptd_controller.sv
rtl/core/primality_trial_division_unit.sv
rtl/core/ptd_checker.sv
tb/tb_primality_trial_division_unit.sv
